// ===== sv/tslt_pkg.sv =====
// ============================================================================
// tslt_pkg
// Shared types and constants for the texture slot lifecycle table: command
// and response payloads, slot states, status codes and the slot entry record.
// ============================================================================
`default_nettype none

package tslt_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [2:0] {
        MODE_ACTIVATE   = 3'd0,
        MODE_RESERVE    = 3'd1,
        MODE_CLEAR_RSV  = 3'd2,
        MODE_RELEASE    = 3'd3,
        MODE_UPLOAD_BEG = 3'd4,
        MODE_UPLOAD_END = 3'd5,
        MODE_READ_BEG   = 3'd6,
        MODE_READ_END   = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_INACTIVE = 3'd0,
        ST_WRITABLE = 3'd1,
        ST_READABLE = 3'd2,
        ST_WRITING  = 3'd3,
        ST_READING  = 3'd4
    } t_slot_state;

    typedef enum logic [1:0] {
        RC_OK          = 2'd0,
        RC_BAD_SLOT    = 2'd1,
        RC_WRONG_STATE = 2'd2,
        RC_REUSABLE    = 2'd3
    } t_status;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  slot;
        logic [15:0] frame;
        logic [31:0] generation;
        logic [31:0] byte_size;
        logic        stay_readable;
        logic        image_present;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [31:0] freed_bytes;
        t_slot_state slot_state;
        logic [7:0]  inactive_count;
    } t_rsp;

    // One slot as stored in the entry memory; all zero is the reset value.
    typedef struct packed {
        t_slot_state lifecycle;
        logic        rsv_valid;
        logic [15:0] rsv_frame;
        logic [31:0] rsv_gen;
        logic        cnt_valid;
        logic [15:0] cnt_frame;
        logic [31:0] cnt_gen;
        logic        has_image;
        logic [31:0] image_bytes;
    } t_entry;

endpackage

`default_nettype wire

// ===== sv/tslt_if.sv =====
// ============================================================================
// tslt_if
// Valid/ready channels for commands into and responses out of the table.
// ============================================================================
`default_nettype none

interface tslt_cmd_if;
    import tslt_pkg::*;

    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tslt_rsp_if;
    import tslt_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/texture_slot_lifecycle_table.sv =====
// ============================================================================
// texture_slot_lifecycle_table
// Lifecycle state machine for a table of texture slots, one command at a time.
// ============================================================================
// For each accepted command, the slot's entry is read from the entry RAM in
// the accept cycle, and in S_EXEC it is checked, updated, written back and
// its response loaded into the output register. A new command
// is taken only once the previous one has written back, so there is never a
// read and a write of the same entry in flight together. If the response
// register is still full at write-back time, the command waits until the
// response is taken. No clearing pass follows reset: one valid flag per slot
// makes a never-written entry read as inactive with all tags zero.
`default_nettype none

module texture_slot_lifecycle_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tslt_cmd_if.sink  i_cmd,
    tslt_rsp_if.source o_rsp
);
    import tslt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_fsm;

    t_fsm                  r_state;
    t_cmd                  r_cmd;
    t_rsp                  r_rsp;
    logic                  r_rsp_valid;
    logic [7:0]            r_free;
    logic [SLOT_COUNT-1:0] r_vld;

    logic                  cmd_accept;
    logic                  out_free;
    logic                  bad_slot;
    logic                  do_write;
    logic [SLOT_AW-1:0]    widx;
    logic [$bits(t_entry)-1:0] rdata;
    t_entry                cur;
    t_entry                n_entry;
    t_rsp                  n_rsp;
    logic [7:0]            n_free;
    logic                  rsv_match;
    logic                  tags_equal;

    assign cmd_accept  = (r_state == S_IDLE) && i_cmd.valid;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign out_free    = !r_rsp_valid || o_rsp.ready;
    assign bad_slot    = (r_cmd.slot >= 8'(SLOT_COUNT));
    assign widx        = r_cmd.slot[SLOT_AW-1:0];
    assign do_write    = (r_state == S_EXEC) && out_free && !bad_slot;

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    tslt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOT_COUNT)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (widx),
        .i_wdata (n_entry),
        .i_re    (cmd_accept),
        .i_raddr (i_cmd.data.slot[SLOT_AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        // Unwritten entries read as the reset value.
        cur = r_vld[widx] ? t_entry'(rdata) : '0;

        rsv_match  = cur.cnt_valid && (cur.cnt_frame == r_cmd.frame) &&
                     (cur.cnt_gen == r_cmd.generation) && cur.has_image;
        tags_equal = (cur.rsv_valid == cur.cnt_valid) &&
                     (cur.rsv_frame == cur.cnt_frame) &&
                     (cur.rsv_gen == cur.cnt_gen);

        n_entry              = cur;
        n_free               = r_free;
        n_rsp.status         = RC_OK;
        n_rsp.freed_bytes    = '0;
        n_rsp.slot_state     = cur.lifecycle;

        if (bad_slot) begin
            n_rsp.status     = RC_BAD_SLOT;
            n_rsp.slot_state = ST_INACTIVE;
        end else begin
            unique case (r_cmd.mode)
                MODE_ACTIVATE: begin
                    if (cur.lifecycle == ST_INACTIVE) begin
                        if (r_free != 8'd0) begin
                            n_free = r_free - 8'd1;
                        end
                        n_entry.rsv_valid = 1'b0;
                        n_entry.rsv_frame = '0;
                        n_entry.rsv_gen   = '0;
                        n_entry.cnt_valid = 1'b0;
                        n_entry.cnt_frame = '0;
                        n_entry.cnt_gen   = '0;
                        n_rsp.slot_state  = ST_WRITABLE;
                    end
                end
                MODE_RESERVE: begin
                    if (cur.lifecycle == ST_WRITABLE || cur.lifecycle == ST_READABLE) begin
                        n_entry.rsv_valid = 1'b1;
                        n_entry.rsv_frame = r_cmd.frame;
                        n_entry.rsv_gen   = r_cmd.generation;
                        n_rsp.slot_state  = rsv_match ? ST_READABLE : ST_WRITABLE;
                    end else begin
                        n_rsp.status = RC_WRONG_STATE;
                    end
                end
                MODE_CLEAR_RSV: begin
                    if (cur.lifecycle == ST_WRITABLE || cur.lifecycle == ST_READABLE) begin
                        n_entry.rsv_valid = 1'b0;
                        n_entry.rsv_frame = '0;
                        n_entry.rsv_gen   = '0;
                        n_rsp.slot_state  = ST_WRITABLE;
                    end else begin
                        n_rsp.status = RC_WRONG_STATE;
                    end
                end
                MODE_RELEASE: begin
                    if (cur.lifecycle != ST_WRITABLE) begin
                        n_rsp.status = RC_WRONG_STATE;
                    end else if (cur.rsv_valid && tags_equal && cur.has_image) begin
                        // Reservation still matches live content: keep it.
                        n_rsp.status = RC_REUSABLE;
                    end else begin
                        n_rsp.freed_bytes    = cur.image_bytes;
                        n_entry.image_bytes  = '0;
                        n_entry.has_image    = 1'b0;
                        n_entry.cnt_valid    = 1'b0;
                        n_entry.cnt_frame    = '0;
                        n_entry.cnt_gen      = '0;
                    end
                end
                MODE_UPLOAD_BEG: begin
                    if (cur.lifecycle == ST_WRITABLE) begin
                        n_entry.cnt_valid = 1'b0;
                        n_entry.cnt_frame = '0;
                        n_entry.cnt_gen   = '0;
                        n_rsp.slot_state  = ST_WRITING;
                    end else begin
                        n_rsp.status = RC_WRONG_STATE;
                    end
                end
                MODE_UPLOAD_END: begin
                    if (cur.lifecycle == ST_WRITING) begin
                        n_entry.cnt_valid   = 1'b1;
                        n_entry.cnt_frame   = r_cmd.frame;
                        n_entry.cnt_gen     = r_cmd.generation;
                        n_entry.image_bytes = r_cmd.byte_size;
                        n_entry.has_image   = r_cmd.image_present;
                        n_rsp.slot_state    = r_cmd.stay_readable ? ST_READABLE : ST_WRITABLE;
                    end else begin
                        n_rsp.status = RC_WRONG_STATE;
                    end
                end
                MODE_READ_BEG: begin
                    if (cur.lifecycle == ST_READABLE) begin
                        n_rsp.slot_state = ST_READING;
                    end else begin
                        n_rsp.status = RC_WRONG_STATE;
                    end
                end
                MODE_READ_END: begin
                    if (cur.lifecycle == ST_READING) begin
                        n_rsp.slot_state = tags_equal ? ST_READABLE : ST_WRITABLE;
                    end else begin
                        n_rsp.status = RC_WRONG_STATE;
                    end
                end
                default: begin
                    n_rsp.status = RC_WRONG_STATE;
                end
            endcase
            n_entry.lifecycle = n_rsp.slot_state;
        end

        n_rsp.inactive_count = n_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_free      <= 8'(SLOT_COUNT);
            r_vld       <= '0;
        end else begin
            // In S_EXEC the response register is either held or reloaded below.
            if (r_rsp_valid && o_rsp.ready && r_state != S_EXEC) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_accept) begin
                        r_cmd   <= i_cmd.data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // Hold until the response register can take the result.
                    if (out_free) begin
                        r_rsp       <= n_rsp;
                        r_rsp_valid <= 1'b1;
                        r_free      <= n_free;
                        if (!bad_slot) begin
                            r_vld[widx] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/tslt_ram.sv =====
// ============================================================================
// tslt_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module tslt_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== bench/texture_slot_lifecycle_table_tb.sv =====
// ============================================================================
// texture_slot_lifecycle_table_tb
// Self-checking bench for the texture slot lifecycle table. Directed commands
// cover bad slots, wrong states, reusable content and the tag comparisons;
// random per-slot lifecycles with noise follow. An in-bench slot table
// predicts every response, and the monitor compares each field in order.
// ============================================================================
module texture_slot_lifecycle_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tslt_pkg::*;

    logic clk;
    logic rst_n;

    tslt_cmd_if cmd_ch();
    tslt_rsp_if rsp_ch();

    texture_slot_lifecycle_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_cmd        cmd_backlog[$];
    t_rsp        predicted_rsp[$];
    t_entry      slot_table[SLOT_COUNT];
    int unsigned inactive_left;
    int unsigned cmds_queued;
    int unsigned cmds_taken;
    int unsigned mismatch_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the slot table by one command and return the response it gives.
    function automatic t_rsp apply_slot_command(t_cmd c);
        t_rsp   r;
        t_entry e;
        r.status         = RC_OK;
        r.freed_bytes    = '0;
        r.slot_state     = ST_INACTIVE;
        if (c.slot >= SLOT_COUNT) begin
            r.status = RC_BAD_SLOT;
        end else begin
            e = slot_table[c.slot];
            case (c.mode)
                MODE_ACTIVATE: begin
                    if (e.lifecycle == ST_INACTIVE) begin
                        if (inactive_left > 0) inactive_left--;
                        e.rsv_valid = 1'b0;
                        e.rsv_frame = '0;
                        e.rsv_gen   = '0;
                        e.cnt_valid = 1'b0;
                        e.cnt_frame = '0;
                        e.cnt_gen   = '0;
                        e.lifecycle = ST_WRITABLE;
                    end
                end
                MODE_RESERVE: begin
                    if (e.lifecycle != ST_WRITABLE && e.lifecycle != ST_READABLE) begin
                        r.status = RC_WRONG_STATE;
                    end else begin
                        e.rsv_valid = 1'b1;
                        e.rsv_frame = c.frame;
                        e.rsv_gen   = c.generation;
                        e.lifecycle = (e.cnt_valid && e.cnt_frame == c.frame &&
                                       e.cnt_gen == c.generation && e.has_image)
                                      ? ST_READABLE : ST_WRITABLE;
                    end
                end
                MODE_CLEAR_RSV: begin
                    if (e.lifecycle != ST_WRITABLE && e.lifecycle != ST_READABLE) begin
                        r.status = RC_WRONG_STATE;
                    end else begin
                        e.rsv_valid = 1'b0;
                        e.rsv_frame = '0;
                        e.rsv_gen   = '0;
                        e.lifecycle = ST_WRITABLE;
                    end
                end
                MODE_RELEASE: begin
                    if (e.lifecycle != ST_WRITABLE) begin
                        r.status = RC_WRONG_STATE;
                    end else if (e.rsv_valid && e.cnt_valid && e.cnt_frame == e.rsv_frame &&
                                 e.cnt_gen == e.rsv_gen && e.has_image) begin
                        r.status = RC_REUSABLE;
                    end else begin
                        r.freed_bytes    = e.image_bytes;
                        e.image_bytes    = '0;
                        e.has_image      = 1'b0;
                        e.cnt_valid      = 1'b0;
                        e.cnt_frame      = '0;
                        e.cnt_gen        = '0;
                    end
                end
                MODE_UPLOAD_BEG: begin
                    if (e.lifecycle != ST_WRITABLE) begin
                        r.status = RC_WRONG_STATE;
                    end else begin
                        e.cnt_valid = 1'b0;
                        e.cnt_frame = '0;
                        e.cnt_gen   = '0;
                        e.lifecycle = ST_WRITING;
                    end
                end
                MODE_UPLOAD_END: begin
                    if (e.lifecycle != ST_WRITING) begin
                        r.status = RC_WRONG_STATE;
                    end else begin
                        e.cnt_valid   = 1'b1;
                        e.cnt_frame   = c.frame;
                        e.cnt_gen     = c.generation;
                        e.image_bytes = c.byte_size;
                        e.has_image   = c.image_present;
                        e.lifecycle   = c.stay_readable ? ST_READABLE : ST_WRITABLE;
                    end
                end
                MODE_READ_BEG: begin
                    if (e.lifecycle != ST_READABLE) r.status = RC_WRONG_STATE;
                    else e.lifecycle = ST_READING;
                end
                default: begin
                    if (e.lifecycle != ST_READING) begin
                        r.status = RC_WRONG_STATE;
                    end else begin
                        e.lifecycle = (e.rsv_valid == e.cnt_valid && e.rsv_frame == e.cnt_frame &&
                                       e.rsv_gen == e.cnt_gen) ? ST_READABLE : ST_WRITABLE;
                    end
                end
            endcase
            slot_table[c.slot] = e;
            r.slot_state       = e.lifecycle;
        end
        r.inactive_count = inactive_left[7:0];
        return r;
    endfunction

    // Driver: hold the command while stalled, else offer the next one or idle.
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) slot_table[i] = '0;
            inactive_left = SLOT_COUNT;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                predicted_rsp.push_back(apply_slot_command(cmd_ch.data));
                cmds_taken++;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.data  <= cmd_backlog.pop_front();
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each response transfer against the oldest prediction.
    always @(posedge clk) begin
        t_rsp want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (predicted_rsp.size() == 0) begin
                    $display("%0t: unexpected response, actual %p", $realtime, rsp_ch.data);
                    mismatch_count++;
                end else begin
                    want = predicted_rsp.pop_front();
                    if (rsp_ch.data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, rsp_ch.data.status);
                        mismatch_count++;
                    end
                    if (rsp_ch.data.freed_bytes !== want.freed_bytes) begin
                        $display("%0t: freed_bytes expected %h actual %h",
                                 $realtime, want.freed_bytes, rsp_ch.data.freed_bytes);
                        mismatch_count++;
                    end
                    if (rsp_ch.data.slot_state !== want.slot_state) begin
                        $display("%0t: slot_state expected %0d actual %0d",
                                 $realtime, want.slot_state, rsp_ch.data.slot_state);
                        mismatch_count++;
                    end
                    if (rsp_ch.data.inactive_count !== want.inactive_count) begin
                        $display("%0t: inactive_count expected %0d actual %0d",
                                 $realtime, want.inactive_count, rsp_ch.data.inactive_count);
                        mismatch_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_cmd(input t_mode m, input int s, input logic [15:0] f,
                             input logic [31:0] g, input logic [31:0] b,
                             input logic k, input logic p);
        t_cmd c;
        c.mode          = m;
        c.slot          = s[7:0];
        c.frame         = f;
        c.generation    = g;
        c.byte_size     = b;
        c.stay_readable = k;
        c.image_present = p;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // Fields the command ignores get random values.
    task automatic queue_plain(input t_mode m, input int s);
        queue_cmd(m, s, 16'($urandom), $urandom, $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // Small pools make tag matches common; the full range still shows up.
    function automatic logic [15:0] pick_frame();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_gen();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 3));
            default: return 32'($urandom);
        endcase
    endfunction

    // One plausible lifecycle on a random slot, with random tags and choices.
    task automatic queue_slot_episode();
        int          s;
        logic [15:0] rsv_f, up_f;
        logic [31:0] rsv_g, up_g;
        logic        keep;
        s     = $urandom_range(0, SLOT_COUNT - 1);
        rsv_f = pick_frame();
        rsv_g = pick_gen();
        up_f  = $urandom_range(0, 2) != 0 ? rsv_f : pick_frame();
        up_g  = $urandom_range(0, 2) != 0 ? rsv_g : pick_gen();
        keep  = 1'($urandom_range(0, 1));
        queue_plain(MODE_ACTIVATE, s);
        if ($urandom_range(0, 1)) queue_cmd(MODE_RESERVE, s, rsv_f, rsv_g, $urandom,
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) begin
            queue_plain(MODE_UPLOAD_BEG, s);
            queue_cmd(MODE_UPLOAD_END, s, up_f, up_g, $urandom, keep,
                      $urandom_range(0, 3) != 0);
        end
        if (!keep && $urandom_range(0, 1))
            queue_cmd(MODE_RESERVE, s, rsv_f, rsv_g, $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) begin
            queue_plain(MODE_READ_BEG, s);
            queue_plain(MODE_READ_END, s);
        end
        if ($urandom_range(0, 2) == 0) queue_plain(MODE_CLEAR_RSV, s);
        queue_plain(MODE_RELEASE, s);
        if ($urandom_range(0, 1)) queue_cmd(MODE_RESERVE, s, pick_frame(), pick_gen(),
                                            $urandom, 1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)));
    endtask

    task automatic queue_random_phase(input int unsigned count);
        int unsigned stop_at;
        stop_at = cmds_queued + count;
        while (cmds_queued < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_plain(t_mode'($urandom_range(0, 7)),
                            $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, SLOT_COUNT - 1));
            end else begin
                queue_slot_episode();
            end
        end
    endtask

    task automatic drain();
        while (cmds_taken != cmds_queued || predicted_rsp.size() != 0) @(posedge clk);
    endtask

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        clk            = 1'b0;
        cmds_queued    = 0;
        cmds_taken     = 0;
        mismatch_count = 0;
        send_idle_pct  = 16;
        recv_stall_pct = 55;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // bad slots, commands on an inactive slot, activation
        queue_cmd(MODE_ACTIVATE,   8'hFF,      '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_RESERVE,    SLOT_COUNT, '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_RESERVE,    0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_READ_END,   0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_ACTIVATE,   0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_ACTIVATE,   0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_RELEASE,    0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_READ_BEG,   0,          '0, '0, '0, 1'b0, 1'b0);
        // upload at the top of every field, then read with unequal tags
        queue_cmd(MODE_UPLOAD_BEG, 0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_UPLOAD_BEG, 0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_UPLOAD_END, 0, 16'hFFFF, '1, '1, 1'b1, 1'b1);
        queue_cmd(MODE_READ_BEG,   0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_READ_END,   0,          '0, '0, '0, 1'b0, 1'b0);
        // matching reservation, read with equal tags, release the image
        queue_cmd(MODE_RESERVE,    0, 16'hFFFF, '1, '0, 1'b0, 1'b0);
        queue_cmd(MODE_RELEASE,    0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_READ_BEG,   0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_READ_END,   0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_CLEAR_RSV,  0,          '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_RELEASE,    0,          '0, '0, '0, 1'b0, 1'b0);
        // last slot: reusable content blocks release
        queue_cmd(MODE_ACTIVATE,   SLOT_COUNT - 1, '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_RESERVE,    SLOT_COUNT - 1, '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_UPLOAD_BEG, SLOT_COUNT - 1, '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_UPLOAD_END, SLOT_COUNT - 1, '0, '0, 32'd1, 1'b0, 1'b1);
        queue_cmd(MODE_RELEASE,    SLOT_COUNT - 1, '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_UPLOAD_BEG, SLOT_COUNT - 1, '0, '0, '0, 1'b0, 1'b0);
        queue_cmd(MODE_UPLOAD_END, SLOT_COUNT - 1, 16'd1, '0, 32'd7, 1'b1, 1'b0);

        queue_random_phase(250);
        drain();
        send_idle_pct  = 55;
        recv_stall_pct = 16;
        queue_random_phase(265);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_phase(265);
        drain();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
